FILE: rtl/fdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_pkg: shared types and constants for the frame descrambler
// Byte and position widths and the frame checksum step.
// ----------------------------------------------------------------------------
package fdc_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 8;
  localparam int SUM_W  = 16;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [SUM_W-1:0]  sum_t;

  // XOR mask that applies the inversion of the differential decode.
  localparam byte_t DEC_INVERT = 8'hFF;

  // One step of the frame's rotate-and-XOR checksum.
  function automatic sum_t sum_step(input sum_t acc, input byte_t d);
    byte_t v;
    byte_t t;
    byte_t s;
    logic  p6;
    logic  p7;
    v  = {d[0], d[7:1]};
    v  = v ^ (v >> 2);
    p6 = acc[0] ^ acc[2] ^ acc[4];
    p7 = acc[1] ^ acc[3] ^ acc[5];
    t  = {p7, p6, acc[5:0]};
    s  = acc[14:7];
    s  = s ^ (s >> 2);
    return {acc[7:0], v ^ t ^ s};
  endfunction

endpackage

FILE: rtl/frame_descramble_and_checksum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_descramble_and_checksum: telemetry frame decoder and checksum check
//
// Usage:
//   Input channel (byte_valid / byte_ready) carries one raw frame byte per
//   request, with frame_start set on the first byte of a frame. Output
//   channel (result_valid / result_ready) carries one decoded byte per
//   request; frame_last marks the final byte of a frame, and check_ok on
//   that byte tells whether the received checksum matches the computed one.
//   Each result is registered: it appears in the cycle after its byte is accepted.
//   Throughput: one byte per cycle while the receiver keeps up; decode and
//   checksum step are combinational logic between the port inputs and the registers.
//   A new byte is accepted whenever the result register is empty or is
//   being drained in the same cycle, so a stalled receiver holds the result
//   and back-pressures the sender without dropping anything.
//   Reset clears the result register, the byte position, the carried bit
//   and the running checksum; the first byte after reset is position 0 of
//   a frame even without frame_start. After the final byte the running
//   state returns to zero, so the next byte opens a new frame.
// ----------------------------------------------------------------------------
module frame_descramble_and_checksum
  import fdc_pkg::*;
#(
  parameter int FRAME_LENGTH = 101
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_ready,
  input  logic [BYTE_W-1:0] raw_byte,
  input  logic             frame_start,
  output logic             result_valid,
  input  logic             result_ready,
  output logic [BYTE_W-1:0] data_byte,
  output logic             frame_last,
  output logic             check_ok
);

  // Frame length in one bit more than the position, so position sums never wrap.
  localparam logic [POS_W:0] FRAME_LEN = (POS_W + 1)'(FRAME_LENGTH);

  // Running frame state.
  logic  carry_bit;
  sum_t  running_sum;
  pos_t  byte_position;
  byte_t expected_high;

  logic  accept;
  logic  cur_carry;
  sum_t  cur_sum;
  logic [POS_W:0] cur_pos;
  byte_t dec;
  logic  in_sum;
  logic  is_high;
  logic  is_last;
  sum_t  sum_next;

  // Accept while the result register is free or drains this cycle.
  assign byte_ready = !result_valid || result_ready;
  assign accept     = byte_valid && byte_ready;

  always_comb begin
    // A start flag restarts position, carried bit and checksum for this byte.
    cur_pos   = frame_start ? '0 : {1'b0, byte_position};
    cur_carry = frame_start ? 1'b0 : carry_bit;
    cur_sum   = frame_start ? '0 : running_sum;

    // Differential decode: each bit against the next higher one (the top bit against the carried bit), inverted.
    dec = raw_byte ^ DEC_INVERT ^ {cur_carry, raw_byte[BYTE_W-1:1]};

    // Payload bytes feed the checksum; the next-to-last byte is the high
    // half of the expected checksum; the last byte closes the frame.
    in_sum  = (cur_pos >= (POS_W + 1)'(2)) && ((cur_pos + (POS_W + 1)'(3)) <= FRAME_LEN);
    is_high = (cur_pos + (POS_W + 1)'(2)) == FRAME_LEN;
    is_last = (cur_pos + (POS_W + 1)'(1)) >= FRAME_LEN;

    sum_next = in_sum ? sum_step(cur_sum, dec) : cur_sum;
  end

  // Frame state: advance on every accepted byte, drop back to zero after last.
  always_ff @(posedge clk) begin
    if (rst) begin
      carry_bit     <= 1'b0;
      running_sum   <= '0;
      byte_position <= '0;
      expected_high <= '0;
    end else if (accept) begin
      if (is_high) begin
        expected_high <= dec;
      end
      if (is_last) begin
        carry_bit     <= 1'b0;
        running_sum   <= '0;
        byte_position <= '0;
      end else begin
        carry_bit     <= raw_byte[0];
        running_sum   <= sum_next;
        byte_position <= cur_pos[POS_W-1:0] + POS_W'(1);
      end
    end
  end

  // Result register: hold while stalled, load on accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_byte  <= dec;
      frame_last <= is_last;
      check_ok   <= is_last && (cur_sum == {expected_high, dec});
    end
  end

endmodule

FILE: rtl/fdc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_checker: port-level checks for the frame descrambler
// Watches the handshakes and result flags of the top level.
// ----------------------------------------------------------------------------
module fdc_checker
  import fdc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              byte_valid,
  input logic              byte_ready,
  input logic              result_valid,
  input logic              result_ready,
  input logic [BYTE_W-1:0] data_byte,
  input logic              frame_last,
  input logic              check_ok
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result pending after reset");

  // A match report only comes with the final byte.
  a_ok_on_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && check_ok |-> frame_last)
    else $error("check_ok without frame_last");

  // An empty result register never back-pressures the sender.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> byte_ready)
    else $error("input stalled with empty result register");

  // Every accepted byte produces a result on the next cycle.
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_ready |=> result_valid)
    else $error("accepted byte produced no result");

  // A stalled result holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(data_byte) && $stable(frame_last) && $stable(check_ok))
    else $error("stalled result changed");

endmodule

bind frame_descramble_and_checksum fdc_checker u_fdc_checker (.*);

FILE: tb/sv/tb_frame_descramble_and_checksum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_descramble_and_checksum: self-checking bench for the frame decoder
// Drives raw frame bytes through the valid/ready request channel and predicts
// every decoded byte, the frame_last flag and the checksum verdict from a
// private model of the decoder state. Most stimulus is scrambled frames whose
// checksum is built to match, some of them corrupted, mixed with cut-short
// frames and raw noise. Both sides idle at random. The receiver holds off once
// for a long stretch so the block fills up and stalls its input.
// ----------------------------------------------------------------------------

typedef struct {
  logic [7:0] data;
  logic       last;
  logic       ok;
} decoded_t;

// Predicts the decoder and scores what comes out of it.
class frame_checker;
  int         frame_len;
  logic       carry;
  logic [15:0] running;
  logic [7:0] pos;
  logic [7:0] sum_high;
  decoded_t   pending_q[$];
  int         errors;

  function new(int len);
    frame_len = len;
    carry     = 1'b0;
    running   = '0;
    pos       = '0;
    sum_high  = '0;
    errors    = 0;
  endfunction

  // Fold one decoded byte into the rotate-and-XOR checksum.
  static function logic [15:0] fold_byte(logic [15:0] acc, logic [7:0] d);
    logic [7:0] rot;
    logic [7:0] mix;
    logic [7:0] low;
    logic [7:0] tail;
    rot  = {d[0], d[7:1]};
    mix  = rot ^ {2'b00, rot[7:2]};
    low  = {acc[5] ^ acc[3] ^ acc[1], acc[4] ^ acc[2] ^ acc[0], acc[5:0]};
    tail = acc[14:7] ^ {2'b00, acc[14:9]};
    return {acc[7:0], mix ^ low ^ tail};
  endfunction

  // Advance the model by one accepted request and queue its result.
  function void note_request(logic [7:0] raw, logic start);
    decoded_t r;
    int       p;
    if (start) begin
      pos     = '0;
      carry   = 1'b0;
      running = '0;
    end
    p      = pos;
    r.data = ~(raw ^ {carry, raw[7:1]});
    r.last = 1'b0;
    r.ok   = 1'b0;
    carry  = raw[0];
    // Header bytes stay out of the checksum; the byte before last is its high half.
    if (p >= 2 && p + 3 <= frame_len) running = fold_byte(running, r.data);
    else if (p + 2 == frame_len) sum_high = r.data;
    if (p + 1 >= frame_len) begin
      r.last  = 1'b1;
      r.ok    = (running == {sum_high, r.data});
      pos     = '0;
      carry   = 1'b0;
      running = '0;
    end else begin
      pos = pos + 8'd1;
    end
    pending_q.push_back(r);
  endfunction

  task report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // Compare one result against the oldest prediction.
  task check_result(logic [7:0] d, logic l, logic k);
    decoded_t e;
    if (pending_q.size() == 0) begin
      report($sformatf("unexpected result data=%02h last=%0b ok=%0b", d, l, k));
    end else begin
      e = pending_q.pop_front();
      if (d !== e.data) report($sformatf("data_byte %02h, want %02h", d, e.data));
      if (l !== e.last) report($sformatf("frame_last %0b, want %0b", l, e.last));
      if (k !== e.ok)   report($sformatf("check_ok %0b, want %0b", k, e.ok));
    end
  endtask

  function int outstanding();
    return pending_q.size();
  endfunction

  function bit at_frame_edge();
    return pos == 8'd0;
  endfunction
endclass

module tb_frame_descramble_and_checksum;

  localparam int FRAME_LEN   = 101;
  localparam int IDLE_PCT    = 15;
  localparam int RANDOM_ITEMS = 1400;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      byte_valid   = 1'b0;
  logic                      byte_ready;
  logic [fdc_pkg::BYTE_W-1:0] raw_byte    = '0;
  logic                      frame_start  = 1'b0;
  logic                      result_valid;
  logic                      result_ready = 1'b0;
  logic [fdc_pkg::BYTE_W-1:0] data_byte;
  logic                      frame_last;
  logic                      check_ok;

  frame_checker board = new(FRAME_LEN);

  int   cycles    = 0;
  int   sent      = 0;
  bit   calm      = 1'b0;  // no idling on either side while set
  bit   hold_req  = 1'b0;  // ask the receiver for one long hold-off
  int   hold_left = 0;

  frame_descramble_and_checksum #(
    .FRAME_LENGTH(FRAME_LEN)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .raw_byte    (raw_byte),
    .frame_start (frame_start),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .data_byte   (data_byte),
    .frame_last  (frame_last),
    .check_ok    (check_ok)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bound the run; a hung handshake ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one request and hold it until the block takes it. Called right
  // after a rising edge; idle gaps drop valid for whole cycles.
  task automatic send_byte(input logic [7:0] r, input logic s);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid  <= 1'b1;
    raw_byte    <= r;
    frame_start <= s;
    do @(posedge clk); while (!byte_ready);
    board.note_request(r, s);
    sent++;
  endtask

  // Receiver: score each accepted result, then pick ready for the next edge.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready)
        board.check_result(data_byte, frame_last, check_ok);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Sender: directed requests, then frames, cut-short frames and noise.
  initial begin
    logic [7:0]  plain [FRAME_LEN];
    logic [7:0]  raw;
    logic [15:0] sum;
    logic        carry;
    logic        start;
    int          kind;
    int          fill;
    int          round;
    int          n;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // First byte after reset opens a frame even without frame_start.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    // Restart mid-frame right after a byte whose low bit is set: the carried bit must clear.
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    // Back-to-back starts.
    send_byte(8'h00, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'hFF, 1'b0);

    round = 0;
    while (sent < 20 + RANDOM_ITEMS) begin
      round++;
      if (round == 4) hold_req = 1'b1;
      calm = (round >= 6 && round <= 8);
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        // Well-formed frame: build the plain bytes, append the checksum, scramble.
        fill = $urandom_range(0, 9);
        for (int p = 0; p < FRAME_LEN; p++) begin
          if (fill == 0) plain[p] = 8'h00;
          else if (fill == 1) plain[p] = 8'hFF;
          else plain[p] = 8'($urandom_range(0, 255));
        end
        sum = '0;
        for (int p = 2; p <= FRAME_LEN - 3; p++) sum = board.fold_byte(sum, plain[p]);
        plain[FRAME_LEN-2] = sum[15:8];
        plain[FRAME_LEN-1] = sum[7:0];
        if ($urandom_range(0, 99) < 30)
          plain[$urandom_range(0, FRAME_LEN-1)] ^= 8'(1 << $urandom_range(0, 7));
        // Drop frame_start at times when the previous frame just closed.
        start = board.at_frame_edge() ? 1'($urandom_range(0, 1)) : 1'b1;
        carry = 1'b0;
        for (int p = 0; p < FRAME_LEN; p++) begin
          raw[7] = ~plain[p][7] ^ carry;
          for (int i = 6; i >= 0; i--) raw[i] = ~plain[p][i] ^ raw[i+1];
          carry = raw[0];
          send_byte(raw, (p == 0) ? start : 1'b0);
        end
      end else if (kind < 85) begin
        // Cut-short frame of random bytes.
        n = $urandom_range(1, FRAME_LEN - 1);
        for (int p = 0; p < n; p++) send_byte(8'($urandom_range(0, 255)), p == 0);
      end else begin
        // Noise with stray starts.
        n = $urandom_range(1, 20);
        for (int p = 0; p < n; p++)
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
    end
    calm = 1'b0;
    byte_valid <= 1'b0;

    // Drain, then let the pipeline settle.
    while (board.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/fdc_pkg.sv
rtl/frame_descramble_and_checksum.sv
rtl/fdc_checker.sv
tb/sv/tb_frame_descramble_and_checksum.sv
